/* hdl/mi3_pkg.sv */
// Shared types, widths and constants for the 3x3 matrix inverse pipeline.
// No dependencies.
`timescale 1ns / 1ps
package mi3_pkg;

  localparam int unsigned ENT_W = 16;
  localparam int unsigned COF_W = 32;
  localparam int unsigned DET_W = 50;
  localparam int unsigned REM_W = DET_W - 1;
  localparam int unsigned Q_W = 32;
  localparam int unsigned DIV_STAGES = 32;
  localparam int unsigned SING_LEN = DIV_STAGES + 1;
  // input register, four adjugate stages, divider load, divider, output register
  localparam int unsigned LAT = DIV_STAGES + 7;

  typedef logic signed [ENT_W-1:0] ent_t;
  typedef ent_t [8:0] mat_t;
  typedef logic signed [COF_W-1:0] cof_t;
  typedef cof_t [8:0] cof_arr_t;
  typedef logic signed [DET_W-1:0] det_t;

  typedef struct packed {
    logic [Q_W-1:0] q;
    logic clip;
  } div_res_t;

  // cofactor k = a[CF_A]*a[CF_B] - a[CF_C]*a[CF_D]
  localparam int unsigned CF_A [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int unsigned CF_B [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int unsigned CF_C [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int unsigned CF_D [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

endpackage

/* hdl/mi3_adj.sv */
// Cofactor and determinant stages: products, cofactors, det terms, det sum.
// Depends on mi3_pkg.
`timescale 1ns / 1ps
module mi3_adj (
  input  logic               clk,
  input  mi3_pkg::mat_t      mat,
  output mi3_pkg::cof_arr_t  cof,
  output mi3_pkg::det_t      det
);
  import mi3_pkg::*;

  logic signed [2*ENT_W-1:0] p_ab [9];
  logic signed [2*ENT_W-1:0] p_cd [9];
  ent_t a_s2 [3];
  ent_t a_s3 [3];
  cof_arr_t cof_s3;
  cof_arr_t cof_s4;
  logic signed [ENT_W+COF_W-1:0] dp [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      p_ab[i] <= signed'(mat[CF_A[i]]) * signed'(mat[CF_B[i]]);
      p_cd[i] <= signed'(mat[CF_C[i]]) * signed'(mat[CF_D[i]]);
      cof_s3[i] <= p_ab[i] - p_cd[i];
    end
    for (int j = 0; j < 3; j++) begin
      a_s2[j] <= signed'(mat[j]);
      a_s3[j] <= a_s2[j];
    end
    dp[0] <= a_s3[0] * signed'(cof_s3[0]);
    dp[1] <= a_s3[1] * signed'(cof_s3[3]);
    dp[2] <= a_s3[2] * signed'(cof_s3[6]);
    cof_s4 <= cof_s3;
    cof <= cof_s4;
    det <= DET_W'(dp[0]) + DET_W'(dp[1]) + DET_W'(dp[2]);
  end

endmodule

/* hdl/mi3_div.sv */
// One lane: pipelined restoring divider, one quotient bit per stage, saturated.
// Depends on mi3_pkg.
`timescale 1ns / 1ps
module mi3_div (
  input  logic               clk,
  input  mi3_pkg::cof_t      cof,
  input  mi3_pkg::det_t      det,
  output mi3_pkg::div_res_t  res
);
  import mi3_pkg::*;

  logic [COF_W-1:0] cmag;
  logic [REM_W-1:0] dmag;

  logic [REM_W-1:0] rem [DIV_STAGES+1];
  logic [REM_W-1:0] den [DIV_STAGES+1];
  logic [Q_W-1:0]   qv  [DIV_STAGES+1];
  logic [3:0]       lo  [DIV_STAGES+1];
  logic             neg [DIV_STAGES+1];
  logic             ovf [DIV_STAGES+1];

  assign cmag = cof[COF_W-1] ? COF_W'(-cof) : COF_W'(cof);
  assign dmag = det[DET_W-1] ? REM_W'(-det) : REM_W'(det);

  always_ff @(posedge clk) begin
    rem[0] <= REM_W'(cmag[COF_W-1:4]);
    den[0] <= dmag;
    qv[0]  <= '0;
    lo[0]  <= cmag[3:0];
    neg[0] <= cof[COF_W-1] ^ det[DET_W-1];
    ovf[0] <= REM_W'(cmag[COF_W-1:4]) >= dmag;
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic       nb;
    logic [REM_W:0] trial;
    logic       take;
    if (k < 4) begin : g_lo
      assign nb = lo[k][3-k];
    end else begin : g_zero
      assign nb = 1'b0;
    end
    assign trial = {rem[k], nb};
    assign take = trial >= {1'b0, den[k]};
    always_ff @(posedge clk) begin
      rem[k+1] <= take ? REM_W'(trial - {1'b0, den[k]}) : REM_W'(trial);
      qv[k+1]  <= {qv[k][Q_W-2:0], take};
      den[k+1] <= den[k];
      lo[k+1]  <= lo[k];
      neg[k+1] <= neg[k];
      ovf[k+1] <= ovf[k];
    end
  end

  logic [Q_W:0]   lim;
  logic           clip;
  logic [Q_W-1:0] val;

  assign lim  = neg[DIV_STAGES] ? (Q_W+1)'(33'h0_8000_0000) : (Q_W+1)'(33'h0_7FFF_FFFF);
  assign clip = ovf[DIV_STAGES] || ({1'b0, qv[DIV_STAGES]} > lim);
  assign val  = clip ? lim[Q_W-1:0] : qv[DIV_STAGES];
  assign res.q = neg[DIV_STAGES] ? Q_W'(-val) : val;
  assign res.clip = clip;

endmodule

/* hdl/matrix3_inverse_unit.sv */
// Throughput: one matrix per cycle; busy is always low, the 32-stage
// divider lanes take a new item every cycle and the receiver cannot stall.
// Reset (rst, synchronous) clears only the valid pipeline.
// Top level of the 3x3 adjugate inverse; uses mi3_pkg, mi3_adj, mi3_div.
`timescale 1ns / 1ps
module matrix3_inverse_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic signed [15:0] m_r1c1,
  input  logic signed [15:0] m_r1c2,
  input  logic signed [15:0] m_r1c3,
  input  logic signed [15:0] m_r2c1,
  input  logic signed [15:0] m_r2c2,
  input  logic signed [15:0] m_r2c3,
  input  logic signed [15:0] m_r3c1,
  input  logic signed [15:0] m_r3c2,
  input  logic signed [15:0] m_r3c3,
  output logic        done,
  output logic signed [31:0] inv_r1c1,
  output logic signed [31:0] inv_r1c2,
  output logic signed [31:0] inv_r1c3,
  output logic signed [31:0] inv_r2c1,
  output logic signed [31:0] inv_r2c2,
  output logic signed [31:0] inv_r2c3,
  output logic signed [31:0] inv_r3c1,
  output logic signed [31:0] inv_r3c2,
  output logic signed [31:0] inv_r3c3,
  output logic        singular,
  output logic        saturated
);
  import mi3_pkg::*;

  mat_t mat_s1;
  cof_arr_t cof;
  det_t det;
  div_res_t res [9];
  logic [LAT-2:0] vpipe;
  logic [SING_LEN-1:0] spipe;
  logic [8:0] clips;
  logic sg;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    mat_s1 <= {m_r3c3, m_r3c2, m_r3c1, m_r2c3, m_r2c2, m_r2c1, m_r1c3, m_r1c2, m_r1c1};
  end

  mi3_adj u_adj (.clk(clk), .mat(mat_s1), .cof(cof), .det(det));

  for (genvar i = 0; i < 9; i++) begin : g_lane
    mi3_div u_div (.clk(clk), .cof(cof[i]), .det(det), .res(res[i]));
    assign clips[i] = res[i].clip;
  end

  assign sg = spipe[SING_LEN-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
      done <= 1'b0;
    end else begin
      vpipe <= {vpipe[LAT-3:0], start & ~busy};
      done <= vpipe[LAT-2];
    end
    spipe <= {spipe[SING_LEN-2:0], det == '0};
    inv_r1c1 <= sg ? '0 : res[0].q;
    inv_r1c2 <= sg ? '0 : res[1].q;
    inv_r1c3 <= sg ? '0 : res[2].q;
    inv_r2c1 <= sg ? '0 : res[3].q;
    inv_r2c2 <= sg ? '0 : res[4].q;
    inv_r2c3 <= sg ? '0 : res[5].q;
    inv_r3c1 <= sg ? '0 : res[6].q;
    inv_r3c2 <= sg ? '0 : res[7].q;
    inv_r3c3 <= sg ? '0 : res[8].q;
    singular <= sg;
    saturated <= ~sg & (|clips);
  end

  a_sing_no_sat: assert property (@(posedge clk) disable iff (rst)
    done && singular |-> !saturated) else $error("singular with saturated");
  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    done && singular |-> inv_r1c1 == 0 && inv_r2c2 == 0 && inv_r3c3 == 0)
    else $error("singular result not zero");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> ##(LAT-1) done) else $error("missing done strobe");

endmodule

/* dv/matrix3_inverse_unit_tb.sv */
// Self-checking testbench for matrix3_inverse_unit: 3x3 adjugate inverse in fixed point.
// Predicts each inverse in-bench and compares every done strobe in order.
// Depends on hdl/mi3_pkg.sv and hdl/matrix3_inverse_unit.sv.
`timescale 1ns / 1ps
module matrix3_inverse_unit_tb;
  import mi3_pkg::*;

  typedef struct {
    logic [31:0] ent [9];
    logic        sing;
    logic        sat;
  } inv_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] m [9];
  logic done;
  logic signed [31:0] inv [9];
  logic singular, saturated;

  inv_t expected_inv [$];
  int errors = 0;
  int idle_cycles = 0;
  localparam int WATCHDOG = 20000;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  matrix3_inverse_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .m_r1c1(m[0]), .m_r1c2(m[1]), .m_r1c3(m[2]),
    .m_r2c1(m[3]), .m_r2c2(m[4]), .m_r2c3(m[5]),
    .m_r3c1(m[6]), .m_r3c2(m[7]), .m_r3c3(m[8]),
    .done(done),
    .inv_r1c1(inv[0]), .inv_r1c2(inv[1]), .inv_r1c3(inv[2]),
    .inv_r2c1(inv[3]), .inv_r2c2(inv[4]), .inv_r2c3(inv[5]),
    .inv_r3c1(inv[6]), .inv_r3c2(inv[7]), .inv_r3c3(inv[8]),
    .singular(singular), .saturated(saturated)
  );

  function automatic inv_t invert(input logic signed [15:0] a [9]);
    inv_t r;
    longint e [9];
    longint cof [9];
    longint det;
    longint unsigned num, den, q, lim;
    logic neg;
    for (int i = 0; i < 9; i++) e[i] = a[i];
    cof[0] = e[4]*e[8] - e[5]*e[7];
    cof[1] = e[2]*e[7] - e[1]*e[8];
    cof[2] = e[1]*e[5] - e[2]*e[4];
    cof[3] = e[5]*e[6] - e[3]*e[8];
    cof[4] = e[0]*e[8] - e[2]*e[6];
    cof[5] = e[2]*e[3] - e[0]*e[5];
    cof[6] = e[3]*e[7] - e[4]*e[6];
    cof[7] = e[1]*e[6] - e[0]*e[7];
    cof[8] = e[0]*e[4] - e[1]*e[3];
    det = e[0]*cof[0] + e[1]*cof[3] + e[2]*cof[6];
    r.sing = (det == 0);
    r.sat = 1'b0;
    for (int i = 0; i < 9; i++) begin
      r.ent[i] = '0;
      if (det != 0) begin
        neg = (cof[i] < 0) != (det < 0);
        num = (cof[i] < 0 ? -cof[i] : cof[i]);
        num = num << 28;
        den = (det < 0 ? -det : det);
        q = num / den;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (q > lim) begin
          q = lim;
          r.sat = 1'b1;
        end
        if (neg) q = -q;
        r.ent[i] = q[31:0];
      end
    end
    return r;
  endfunction

  // one matrix transfer; random gap before it when a new burst starts
  int burst_left = 0;
  task automatic send_matrix(input logic signed [15:0] a [9]);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    for (int i = 0; i < 9; i++) m[i] <= a[i];
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_inv.push_back(invert(a));
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      inv_t x;
      if (expected_inv.size() == 0) begin
        $display("%0t: result with none expected", $time);
        errors++;
      end else begin
        x = expected_inv.pop_front();
        for (int i = 0; i < 9; i++)
          if (inv[i] !== x.ent[i]) begin
            $display("%0t: inv[%0d] expected %h actual %h", $time, i, x.ent[i], inv[i]);
            errors++;
          end
        if (singular !== x.sing) begin
          $display("%0t: singular expected %b actual %b", $time, x.sing, singular);
          errors++;
        end
        if (saturated !== x.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, x.sat, saturated);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic void fill(output logic signed [15:0] a [9], input logic signed [15:0] v);
    for (int i = 0; i < 9; i++) a[i] = v;
  endfunction

  task automatic test_directed();
    logic signed [15:0] a [9];
    fill(a, 16'sd0);
    send_matrix(a);                                 // zero matrix: singular
    a[0] = 16'sd4096; a[4] = 16'sd4096; a[8] = 16'sd4096;
    send_matrix(a);                                 // identity
    a[0] = -16'sd4096; send_matrix(a);
    fill(a, 16'sd0); a[0] = 16'sd1; a[4] = 16'sd1; a[8] = 16'sd1;
    send_matrix(a);                                 // tiny diagonal: large inverse, below saturation
    a[0] = -16'sd1; send_matrix(a);
    fill(a, 16'sd0); a[0] = 16'sh7FFF; a[4] = 16'sh7FFF; a[8] = 16'sh7FFF;
    send_matrix(a);
    fill(a, 16'sd0); a[0] = -16'sd32768; a[4] = -16'sd32768; a[8] = -16'sd32768;
    send_matrix(a);
    fill(a, -16'sd32768); send_matrix(a);           // all equal: singular
    fill(a, 16'sh7FFF); send_matrix(a);
    a = '{16'sh7FFF, -16'sd32768, 16'sd0, 16'sd0, 16'sh7FFF, -16'sd32768,
          -16'sd32768, 16'sd0, 16'sh7FFF};
    send_matrix(a);
    a = '{-16'sd32768, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, -16'sd32768, 16'sh7FFF,
          16'sh7FFF, 16'sh7FFF, -16'sd32768};
    send_matrix(a);
    a = '{16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5, 16'sd6, 16'sd7, 16'sd8, 16'sd10};
    send_matrix(a);                                 // det tiny, large entries
    a = '{16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5, 16'sd6, 16'sd7, 16'sd8, 16'sd9};
    send_matrix(a);                                 // rank deficient
    a = '{16'sd0, 16'sd4096, 16'sd0, 16'sd0, 16'sd0, 16'sd4096, 16'sd4096, 16'sd0, 16'sd0};
    send_matrix(a);                                 // permutation
    a = '{16'sh5555, -16'sh2AAA, 16'sh1234, 16'sh0F0F, 16'sh7000, -16'sh0100,
          -16'sh3333, 16'sh00FF, 16'sh4000};
    send_matrix(a);
  endtask

  task automatic test_random();
    logic signed [15:0] a [9];
    int kind;
    for (int n = 0; n < 1200; n++) begin
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) begin
        case (kind)
          0, 1, 2, 3: a[i] = 16'($urandom);
          4, 5: a[i] = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
          6: a[i] = $signed(16'($urandom_range(0, 6))) - 16'sd3;
          7: a[i] = ($urandom_range(0, 1)) ? 16'sh7FFF : -16'sd32768;
          default: a[i] = (i % 4 == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
        endcase
      end
      // make some rows dependent to hit the singular path
      if (kind == 8 && $urandom_range(0, 1)) for (int i = 0; i < 3; i++) a[6+i] = a[i];
      send_matrix(a);
    end
  endtask

  initial begin
    int wait_cycles;
    rst <= 1'b1;
    for (int i = 0; i < 9; i++) m[i] <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random();
    start <= 1'b0;
    wait_cycles = 0;
    while (expected_inv.size() != 0 && wait_cycles < 2000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (LAT + 5) @(posedge clk);
    if (errors == 0 && expected_inv.size() == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
